// ===== rtl/core/irctm_pkg.sv =====
package irctm_pkg;

	localparam int NUM_MACROS      = 4;
	localparam int STEPS_PER_MACRO = 8;
	localparam int NUM_WAKE        = 8;

	localparam int MACRO_STRIDE  = STEPS_PER_MACRO + 1;
	localparam int MACRO_ENTRIES = NUM_MACROS * MACRO_STRIDE;
	localparam int MADDR_W       = $clog2(MACRO_ENTRIES);
	localparam int MCNT_W        = $clog2(NUM_MACROS + 1);
	localparam int SCNT_W        = $clog2(STEPS_PER_MACRO + 1);
	localparam int WIDX_W        = $clog2(NUM_WAKE);
	localparam int ENTRY_W       = 48;

	localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = '1;

	localparam logic [2:0] KIND_CODE     = 3'd0;
	localparam logic [2:0] KIND_WR_MACRO = 3'd1;
	localparam logic [2:0] KIND_WR_WAKE  = 3'd2;
	localparam logic [2:0] KIND_CL_MACRO = 3'd3;
	localparam logic [2:0] KIND_CL_WAKE  = 3'd4;
	localparam logic [2:0] KIND_RD_MACRO = 3'd5;
	localparam logic [2:0] KIND_RD_WAKE  = 3'd6;
	localparam logic [2:0] KIND_UNUSED   = 3'd7;

	localparam logic [2:0] ACT_TRANSMIT = 3'd0;
	localparam logic [2:0] ACT_WAKEUP   = 3'd1;
	localparam logic [2:0] ACT_RESET    = 3'd2;
	localparam logic [2:0] ACT_REBOOT   = 3'd3;
	localparam logic [2:0] ACT_FORWARD  = 3'd4;
	localparam logic [2:0] ACT_READ     = 3'd5;
	localparam logic [2:0] ACT_ACK      = 3'd6;
	localparam logic [2:0] ACT_REJECT   = 3'd7;

	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_RAM  = 2'd1;
	localparam logic [1:0] SRC_WAKE = 2'd2;
	localparam logic [1:0] SRC_CODE = 2'd3;

	typedef struct packed {
		logic       latch;
		logic       learn;
		logic       mwr;
		logic       wwr;
		logic       clr;
		logic       emit;
		logic [2:0] act;
		logic [1:0] src;
		logic       asel_scan;
		logic       m_init;
		logic       m_next;
		logic       s_init;
		logic       s_inc;
		logic       w_lo;
		logic       w_hi;
		logic       w_inc;
		logic       flush;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       macro_ok;
		logic       wake_ok;
		logic       repeat_req;
		logic       host_up;
		logic       ram_empty;
		logic       ram_match;
		logic       wk_empty;
		logic       wk_match;
		logic       rbt_match;
		logic       m_end;
		logic       s_end;
		logic       w_lo_end;
		logic       w_hi_end;
		logic       emit_ok;
		logic       flush_done;
	} sts_t;

endpackage

// ===== rtl/core/irctm_ram.sv =====
module irctm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/irctm_ctrl.sv =====
module irctm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  irctm_pkg::sts_t  sts,
	output irctm_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DEC     = 4'd1;
	localparam logic [3:0] ST_RDM     = 4'd2;
	localparam logic [3:0] ST_TRIG_RD = 4'd3;
	localparam logic [3:0] ST_TRIG    = 4'd4;
	localparam logic [3:0] ST_STEP_RD = 4'd5;
	localparam logic [3:0] ST_STEP    = 4'd6;
	localparam logic [3:0] ST_WSTART  = 4'd7;
	localparam logic [3:0] ST_WLO     = 4'd8;
	localparam logic [3:0] ST_WHI     = 4'd9;
	localparam logic [3:0] ST_RBT     = 4'd10;
	localparam logic [3:0] ST_FWD     = 4'd11;
	localparam logic [3:0] ST_FLUSH   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] nxt;

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					nxt = ST_DEC;
				end
			end
			ST_DEC: begin
				case (sts.kind) inside
					irctm_pkg::KIND_CODE: begin
						if (sts.repeat_req) begin
							nxt = ST_FWD;
						end else begin
							cmd.learn  = 1'b1;
							cmd.m_init = 1'b1;
							nxt = ST_TRIG_RD;
						end
					end
					irctm_pkg::KIND_WR_MACRO, irctm_pkg::KIND_CL_MACRO: begin
						cmd.emit = 1'b1;
						cmd.act  = sts.macro_ok ? irctm_pkg::ACT_ACK : irctm_pkg::ACT_REJECT;
						cmd.mwr  = sts.macro_ok && sts.emit_ok;
						cmd.clr  = (sts.kind == irctm_pkg::KIND_CL_MACRO);
						if (sts.emit_ok) nxt = ST_FLUSH;
					end
					irctm_pkg::KIND_WR_WAKE, irctm_pkg::KIND_CL_WAKE: begin
						cmd.emit = 1'b1;
						cmd.act  = sts.wake_ok ? irctm_pkg::ACT_ACK : irctm_pkg::ACT_REJECT;
						cmd.wwr  = sts.wake_ok && sts.emit_ok;
						cmd.clr  = (sts.kind == irctm_pkg::KIND_CL_WAKE);
						if (sts.emit_ok) nxt = ST_FLUSH;
					end
					irctm_pkg::KIND_RD_MACRO: begin
						if (sts.macro_ok) begin
							nxt = ST_RDM;
						end else begin
							cmd.emit = 1'b1;
							cmd.act  = irctm_pkg::ACT_REJECT;
							if (sts.emit_ok) nxt = ST_FLUSH;
						end
					end
					irctm_pkg::KIND_RD_WAKE: begin
						cmd.emit = 1'b1;
						if (sts.wake_ok) begin
							cmd.act = irctm_pkg::ACT_READ;
							cmd.src = irctm_pkg::SRC_WAKE;
						end else begin
							cmd.act = irctm_pkg::ACT_REJECT;
						end
						if (sts.emit_ok) nxt = ST_FLUSH;
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.act  = irctm_pkg::ACT_REJECT;
						if (sts.emit_ok) nxt = ST_FLUSH;
					end
				endcase
			end
			ST_RDM: begin
				cmd.emit = 1'b1;
				cmd.act  = irctm_pkg::ACT_READ;
				cmd.src  = irctm_pkg::SRC_RAM;
				if (sts.emit_ok) nxt = ST_FLUSH;
			end
			ST_TRIG_RD: begin
				cmd.asel_scan = 1'b1;
				nxt = sts.m_end ? ST_WSTART : ST_TRIG;
			end
			ST_TRIG: begin
				cmd.asel_scan = 1'b1;
				if (sts.ram_empty) begin
					nxt = ST_WSTART;
				end else if (sts.ram_match) begin
					cmd.s_init = 1'b1;
					nxt = ST_STEP_RD;
				end else begin
					cmd.m_next = 1'b1;
					nxt = ST_TRIG_RD;
				end
			end
			ST_STEP_RD: begin
				cmd.asel_scan = 1'b1;
				nxt = ST_STEP;
			end
			ST_STEP: begin
				cmd.asel_scan = 1'b1;
				if (sts.ram_empty) begin
					cmd.m_next = 1'b1;
					nxt = ST_TRIG_RD;
				end else begin
					cmd.emit = 1'b1;
					cmd.act  = irctm_pkg::ACT_TRANSMIT;
					cmd.src  = irctm_pkg::SRC_RAM;
					if (sts.emit_ok) begin
						if (sts.s_end) begin
							cmd.m_next = 1'b1;
							nxt = ST_TRIG_RD;
						end else begin
							cmd.s_inc = 1'b1;
							nxt = ST_STEP_RD;
						end
					end
				end
			end
			ST_WSTART: begin
				// The lower half of the wake slots is only checked while the host is down.
				if (sts.host_up) begin
					cmd.w_hi = 1'b1;
					nxt = ST_WHI;
				end else begin
					cmd.w_lo = 1'b1;
					nxt = ST_WLO;
				end
			end
			ST_WLO: begin
				cmd.asel_scan = 1'b1;
				if (sts.w_lo_end || sts.wk_empty) begin
					cmd.w_hi = 1'b1;
					nxt = ST_WHI;
				end else if (sts.wk_match) begin
					cmd.emit  = 1'b1;
					cmd.act   = irctm_pkg::ACT_WAKEUP;
					cmd.w_inc = sts.emit_ok;
				end else begin
					cmd.w_inc = 1'b1;
				end
			end
			ST_WHI: begin
				cmd.asel_scan = 1'b1;
				if (sts.w_hi_end || sts.wk_empty) begin
					nxt = ST_RBT;
				end else if (sts.wk_match) begin
					cmd.emit  = 1'b1;
					cmd.act   = irctm_pkg::ACT_RESET;
					cmd.w_inc = sts.emit_ok;
				end else begin
					cmd.w_inc = 1'b1;
				end
			end
			ST_RBT: begin
				if (sts.rbt_match) begin
					cmd.emit = 1'b1;
					cmd.act  = irctm_pkg::ACT_REBOOT;
					if (sts.emit_ok) nxt = ST_FLUSH;
				end else begin
					nxt = ST_FWD;
				end
			end
			ST_FWD: begin
				if (sts.host_up) begin
					cmd.emit = 1'b1;
					cmd.act  = irctm_pkg::ACT_FORWARD;
					cmd.src  = irctm_pkg::SRC_CODE;
					if (sts.emit_ok) nxt = ST_FLUSH;
				end else begin
					nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (sts.flush_done) nxt = ST_IDLE;
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/irctm_dp.sv =====
module irctm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [63:0]                   s_tdata,
	input  logic [2:0]                    s_tuser,
	input  irctm_pkg::cmd_t               cmd,
	output irctm_pkg::sts_t               sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [irctm_pkg::ENTRY_W-1:0] m_tdata,
	output logic [2:0]                    m_tuser,
	output logic                          m_tlast
);

	// Item fields.
	logic [2:0]                    kind_q;
	logic [2:0]                    slot_q;
	logic [3:0]                    pos_q;
	logic [irctm_pkg::ENTRY_W-1:0] code_q;
	logic [7:0]                    flags_q;
	logic                          repeat_q;
	logic                          host_q;

	logic [irctm_pkg::MCNT_W-1:0]  m_q;
	logic [irctm_pkg::MADDR_W-1:0] base_q;
	logic [irctm_pkg::SCNT_W-1:0]  s_q;
	logic [irctm_pkg::WIDX_W-1:0]  w_q;

	logic [irctm_pkg::MACRO_ENTRIES-1:0] valid_q;
	logic                                rvld_q;
	logic [irctm_pkg::ENTRY_W-1:0]       wake_q [irctm_pkg::NUM_WAKE];

	logic                          pend_vld_q;
	logic [2:0]                    pend_act_q;
	logic [irctm_pkg::ENTRY_W-1:0] pend_dat_q;
	logic                          out_vld_q;
	logic [2:0]                    out_act_q;
	logic [irctm_pkg::ENTRY_W-1:0] out_dat_q;
	logic                          out_last_q;

	logic [irctm_pkg::MADDR_W-1:0] midx;
	logic [irctm_pkg::MADDR_W-1:0] raddr;
	logic [irctm_pkg::ENTRY_W-1:0] wr_entry;
	logic [irctm_pkg::ENTRY_W-1:0] ram_rdata;
	logic [irctm_pkg::ENTRY_W-1:0] ram_ent;
	logic [irctm_pkg::WIDX_W-1:0]  widx;
	logic [irctm_pkg::ENTRY_W-1:0] wk_ent;
	logic [irctm_pkg::ENTRY_W-1:0] res_dat;
	logic                          out_free;
	logic                          emit_ok;
	logic                          out_load;

	assign midx = irctm_pkg::MADDR_W'(int'(slot_q) * irctm_pkg::MACRO_STRIDE + int'(pos_q));
	assign raddr = cmd.asel_scan ? (base_q + irctm_pkg::MADDR_W'(s_q)) : midx;
	assign wr_entry = cmd.clr ? irctm_pkg::EMPTY_ENTRY : {code_q[irctm_pkg::ENTRY_W-1:8], flags_q};

	irctm_ram #(
		.WIDTH (irctm_pkg::ENTRY_W),
		.DEPTH (irctm_pkg::MACRO_ENTRIES)
	) u_macro_ram (
		.clk   (clk),
		.we    (cmd.mwr),
		.waddr (midx),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as empty.
	assign ram_ent = rvld_q ? ram_rdata : irctm_pkg::EMPTY_ENTRY;

	assign widx   = cmd.asel_scan ? w_q : slot_q[irctm_pkg::WIDX_W-1:0];
	assign wk_ent = wake_q[widx];

	always_comb begin
		case (cmd.src)
			irctm_pkg::SRC_RAM:  res_dat = ram_ent;
			irctm_pkg::SRC_WAKE: res_dat = wk_ent;
			irctm_pkg::SRC_CODE: res_dat = {code_q[irctm_pkg::ENTRY_W-1:8], 7'd0, repeat_q};
			default:             res_dat = '0;
		endcase
	end

	assign out_free = !out_vld_q || m_tready;
	assign emit_ok  = !pend_vld_q || out_free;
	assign out_load = pend_vld_q && ((cmd.emit && emit_ok) || (cmd.flush && out_free));

	always_comb begin
		sts            = '0;
		sts.kind       = kind_q;
		sts.macro_ok   = (int'(slot_q) < irctm_pkg::NUM_MACROS) &&
			(int'(pos_q) <= irctm_pkg::STEPS_PER_MACRO);
		sts.wake_ok    = (int'(slot_q) < irctm_pkg::NUM_WAKE);
		sts.repeat_req = repeat_q;
		sts.host_up    = host_q;
		sts.ram_empty  = (ram_ent == irctm_pkg::EMPTY_ENTRY);
		sts.ram_match  = (ram_ent == code_q);
		sts.wk_empty   = (wk_ent == irctm_pkg::EMPTY_ENTRY);
		sts.wk_match   = (wk_ent == code_q);
		sts.rbt_match  = (wake_q[irctm_pkg::NUM_WAKE-1] == code_q);
		sts.m_end      = (m_q == irctm_pkg::MCNT_W'(irctm_pkg::NUM_MACROS));
		sts.s_end      = (s_q == irctm_pkg::SCNT_W'(irctm_pkg::STEPS_PER_MACRO));
		sts.w_lo_end   = (w_q == irctm_pkg::WIDX_W'(irctm_pkg::NUM_WAKE / 2));
		sts.w_hi_end   = (w_q == irctm_pkg::WIDX_W'(irctm_pkg::NUM_WAKE - 1));
		sts.emit_ok    = emit_ok;
		sts.flush_done = emit_ok;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= s_tuser;
			slot_q   <= s_tdata[2:0];
			pos_q    <= s_tdata[6:3];
			code_q   <= {s_tdata[14:7], s_tdata[30:15], s_tdata[46:31], 8'd0};
			flags_q  <= s_tdata[54:47];
			repeat_q <= s_tdata[55];
			host_q   <= s_tdata[56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= '0;
			base_q <= '0;
			s_q    <= '0;
			w_q    <= '0;
		end else begin
			if (cmd.m_init) begin
				m_q    <= '0;
				base_q <= '0;
				s_q    <= '0;
			end else if (cmd.m_next) begin
				m_q    <= m_q + 1'b1;
				base_q <= base_q + irctm_pkg::MADDR_W'(irctm_pkg::MACRO_STRIDE);
				s_q    <= '0;
			end else if (cmd.s_init) begin
				s_q <= irctm_pkg::SCNT_W'(1);
			end else if (cmd.s_inc) begin
				s_q <= s_q + 1'b1;
			end
			if (cmd.w_lo) begin
				w_q <= '0;
			end else if (cmd.w_hi) begin
				w_q <= irctm_pkg::WIDX_W'(irctm_pkg::NUM_WAKE / 2);
			end else if (cmd.w_inc) begin
				w_q <= w_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
			for (int i = 0; i < irctm_pkg::NUM_WAKE; i++) begin
				wake_q[i] <= irctm_pkg::EMPTY_ENTRY;
			end
		end else begin
			if (cmd.mwr) begin
				valid_q[midx] <= 1'b1;
			end
			rvld_q <= (int'(raddr) < irctm_pkg::MACRO_ENTRIES) && valid_q[raddr];
			if (cmd.wwr) begin
				wake_q[slot_q[irctm_pkg::WIDX_W-1:0]] <= wr_entry;
			end else if (cmd.learn && (wake_q[0] == irctm_pkg::EMPTY_ENTRY)) begin
				wake_q[0] <= code_q;
			end
		end
	end

	// One result is held back so that the final one can be marked on flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.emit && emit_ok) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.flush && out_load) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && emit_ok) begin
			if (pend_vld_q) begin
				out_act_q  <= pend_act_q;
				out_dat_q  <= pend_dat_q;
				out_last_q <= 1'b0;
			end
			pend_act_q <= cmd.act;
			pend_dat_q <= res_dat;
		end else if (cmd.flush && pend_vld_q && out_free) begin
			out_act_q  <= pend_act_q;
			out_dat_q  <= pend_dat_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {out_dat_q[7:0], out_dat_q[23:8], out_dat_q[39:24], out_dat_q[47:40]};
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/core/ir_code_trigger_matcher.sv =====
// IR code trigger matcher. Each beat on the slave side is one item: a received IR code or a
// write, clear or read of one macro or wake table entry; its results leave on the master side,
// tlast marking the final one, and a received code with nothing to report gives none. One item
// is handled at a time. A received code is paced by the single read port of the macro table
// memory: each trigger or step read passes through a read state and a check state, the wake
// slots are checked one by one, and a stall on the master side holds the scan. The macro table
// is cleared by per-entry valid flags at reset, with no clearing pass.
module ir_code_trigger_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[2:0], position[6:3], protocol[14:7], address[30:15], command[46:31],
	// flags[54:47], repeat_req[55], host_up[56], zero fill[63:57]
	input  logic [63:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// protocol_out[7:0], address_out[23:8], command_out[39:24], flags_out[47:40]
	output logic [47:0] m_tdata,
	// action[2:0]
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	irctm_pkg::cmd_t cmd;
	irctm_pkg::sts_t sts;

	irctm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	irctm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/irctm_checker.sv =====
module irctm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// Acknowledge, reject, read and reboot results are always the final beat of their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == irctm_pkg::ACT_ACK || m_tuser == irctm_pkg::ACT_REJECT ||
		m_tuser == irctm_pkg::ACT_READ || m_tuser == irctm_pkg::ACT_REBOOT) |-> m_tlast)
		else $error("single result not marked last");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == irctm_pkg::ACT_WAKEUP || m_tuser == irctm_pkg::ACT_RESET ||
		m_tuser == irctm_pkg::ACT_REBOOT || m_tuser == irctm_pkg::ACT_ACK ||
		m_tuser == irctm_pkg::ACT_REJECT) |-> (m_tdata == '0))
		else $error("status result carries data");

endmodule

bind ir_code_trigger_matcher irctm_checker u_irctm_checker (.*);

// ===== dv/ir_code_trigger_matcher_checker.sv =====
`timescale 1ns / 100ps

module ir_code_trigger_matcher_checker
	import irctm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	typedef struct packed {
		logic [2:0]         action;
		logic [ENTRY_W-1:0] entry;
		logic               last;
	} outcome_t;

	logic [ENTRY_W-1:0] macro_mem [MACRO_ENTRIES];
	logic [ENTRY_W-1:0] wake_mem [NUM_WAKE];
	outcome_t           outcome_q [$];

	initial begin
		fail_count = 0;
		results_seen = 0;
		for (int i = 0; i < MACRO_ENTRIES; i++) macro_mem[i] = EMPTY_ENTRY;
		for (int i = 0; i < NUM_WAKE; i++) wake_mem[i] = EMPTY_ENTRY;
	end

	assign pending = outcome_q.size();

	function automatic outcome_t make_outcome(logic [2:0] act, logic [ENTRY_W-1:0] e);
		outcome_t o;
		o.action = act;
		o.entry = e;
		o.last = 1'b0;
		return o;
	endfunction

	task automatic predict_item(input logic [2:0] kind, input logic [63:0] d);
		outcome_t           res [$];
		logic [2:0]         slot;
		logic [3:0]         pos;
		logic [ENTRY_W-1:0] code;
		logic [ENTRY_W-1:0] entry;
		logic               rpt;
		logic               up;
		logic               macro_ok;
		logic               wake_ok;
		int                 midx;
		logic               rebooted;
		slot = d[2:0];
		pos = d[6:3];
		code = {d[14:7], d[30:15], d[46:31], 8'h00};
		entry = {d[14:7], d[30:15], d[46:31], d[54:47]};
		rpt = d[55];
		up = d[56];
		macro_ok = (slot < NUM_MACROS) && (pos <= STEPS_PER_MACRO);
		wake_ok = slot < NUM_WAKE;
		midx = slot * MACRO_STRIDE + pos;
		rebooted = 1'b0;
		case (kind)
			KIND_CODE: begin
				if (!rpt) begin
					if (wake_mem[0] == EMPTY_ENTRY) wake_mem[0] = code;
					for (int m = 0; m < NUM_MACROS; m++) begin
						if (macro_mem[m*MACRO_STRIDE] == EMPTY_ENTRY) break;
						if (macro_mem[m*MACRO_STRIDE] == code) begin
							for (int s = 1; s <= STEPS_PER_MACRO; s++) begin
								if (macro_mem[m*MACRO_STRIDE+s] == EMPTY_ENTRY) break;
								res.push_back(make_outcome(ACT_TRANSMIT,
									macro_mem[m*MACRO_STRIDE+s]));
							end
						end
					end
					if (!up) begin
						for (int w = 0; w < NUM_WAKE/2; w++) begin
							if (wake_mem[w] == EMPTY_ENTRY) break;
							if (wake_mem[w] == code) res.push_back(make_outcome(ACT_WAKEUP, '0));
						end
					end
					for (int w = NUM_WAKE/2; w < NUM_WAKE-1; w++) begin
						if (wake_mem[w] == EMPTY_ENTRY) break;
						if (wake_mem[w] == code) res.push_back(make_outcome(ACT_RESET, '0));
					end
					if (wake_mem[NUM_WAKE-1] == code) begin
						res.push_back(make_outcome(ACT_REBOOT, '0));
						rebooted = 1'b1;
					end
				end
				if (!rebooted && up) res.push_back(make_outcome(ACT_FORWARD, code | ENTRY_W'(rpt)));
			end
			KIND_WR_MACRO, KIND_CL_MACRO: begin
				if (!macro_ok) res.push_back(make_outcome(ACT_REJECT, '0));
				else begin
					macro_mem[midx] = (kind == KIND_WR_MACRO) ? entry : EMPTY_ENTRY;
					res.push_back(make_outcome(ACT_ACK, '0));
				end
			end
			KIND_WR_WAKE, KIND_CL_WAKE: begin
				if (!wake_ok) res.push_back(make_outcome(ACT_REJECT, '0));
				else begin
					wake_mem[slot] = (kind == KIND_WR_WAKE) ? entry : EMPTY_ENTRY;
					res.push_back(make_outcome(ACT_ACK, '0));
				end
			end
			KIND_RD_MACRO: begin
				if (!macro_ok) res.push_back(make_outcome(ACT_REJECT, '0));
				else res.push_back(make_outcome(ACT_READ, macro_mem[midx]));
			end
			KIND_RD_WAKE: begin
				if (!wake_ok) res.push_back(make_outcome(ACT_REJECT, '0));
				else res.push_back(make_outcome(ACT_READ, wake_mem[slot]));
			end
			default: res.push_back(make_outcome(ACT_REJECT, '0));
		endcase
		if (res.size() > 0) res[res.size()-1].last = 1'b1;
		foreach (res[i]) outcome_q.push_back(res[i]);
	endtask

	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					$error("unexpected result beat: action %0d data %h", m_tuser, m_tdata);
					fail_count++;
				end else begin
					exp_o = outcome_q.pop_front();
					if (m_tuser !== exp_o.action) begin
						$error("action: expected %0d, got %0d", exp_o.action, m_tuser);
						fail_count++;
					end
					if (m_tdata[7:0] !== exp_o.entry[47:40]) begin
						$error("protocol_out: expected %h, got %h", exp_o.entry[47:40],
							m_tdata[7:0]);
						fail_count++;
					end
					if (m_tdata[23:8] !== exp_o.entry[39:24]) begin
						$error("address_out: expected %h, got %h", exp_o.entry[39:24],
							m_tdata[23:8]);
						fail_count++;
					end
					if (m_tdata[39:24] !== exp_o.entry[23:8]) begin
						$error("command_out: expected %h, got %h", exp_o.entry[23:8],
							m_tdata[39:24]);
						fail_count++;
					end
					if (m_tdata[47:40] !== exp_o.entry[7:0]) begin
						$error("flags_out: expected %h, got %h", exp_o.entry[7:0],
							m_tdata[47:40]);
						fail_count++;
					end
					if (m_tlast !== exp_o.last) begin
						$error("last: expected %0d, got %0d", exp_o.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== dv/ir_code_trigger_matcher_tb.sv =====
`timescale 1ns / 100ps

module ir_code_trigger_matcher_tb;
	import irctm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          items_sent;
	logic        calm;
	logic        hold_off;

	// Codes drawn from a small pool so that random traffic hits the tables.
	logic [39:0] code_pool [8];

	ir_code_trigger_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	ir_code_trigger_matcher_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none once calm.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic [2:0] kind, input logic [2:0] slot,
		input logic [3:0] pos, input logic [39:0] code, input logic [7:0] flg,
		input logic rpt, input logic up);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tuser <= kind;
		s_tdata <= {7'd0, up, rpt, flg, code[15:0], code[31:16], code[39:32], pos, slot};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [39:0] pool_code();
		return code_pool[$urandom_range(0, 7)];
	endfunction

	initial begin
		logic [2:0]  kind;
		logic [39:0] c;
		int          r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_CODE;
		calm = 1'b0;
		hold_off = 1'b0;
		items_sent = 0;
		for (int i = 0; i < 8; i++) code_pool[i] = 40'({$urandom, $urandom});
		code_pool[0] = '1;
		code_pool[1] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reads of empty entries, then learning into wake slot 0 with host down.
		send_item(KIND_RD_MACRO, 3'd0, 4'd0, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_RD_WAKE, 3'd7, 4'd0, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_CODE, 3'd0, 4'd0, code_pool[2], 8'hFF, 1'b0, 1'b0);
		send_item(KIND_CODE, 3'd0, 4'd0, code_pool[2], 8'h00, 1'b0, 1'b0);
		send_item(KIND_CODE, 3'd0, 4'd0, code_pool[3], 8'h00, 1'b1, 1'b1);
		send_item(KIND_CODE, 3'd0, 4'd0, code_pool[3], 8'h00, 1'b1, 1'b0);
		// Two macros on the same trigger, the second one full.
		send_item(KIND_WR_MACRO, 3'd0, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b0);
		send_item(KIND_WR_MACRO, 3'd0, 4'd1, code_pool[1], 8'h00, 1'b0, 1'b0);
		send_item(KIND_WR_MACRO, 3'd1, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b0);
		for (int s = 1; s <= STEPS_PER_MACRO; s++)
			send_item(KIND_WR_MACRO, 3'd1, 4'(s), code_pool[s%8], 8'(s), 1'b0, 1'b0);
		send_item(KIND_WR_WAKE, 3'd4, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b0);
		send_item(KIND_WR_WAKE, 3'd7, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b0);
		send_item(KIND_CODE, 3'd0, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b1);
		// Bad indices, unused kind, writing all ones, then clears and a read.
		send_item(KIND_WR_MACRO, 3'd4, 4'd0, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_RD_MACRO, 3'd0, 4'd15, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_UNUSED, 3'd0, 4'd0, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_WR_WAKE, 3'd7, 4'd0, '1, 8'hFF, 1'b0, 1'b0);
		send_item(KIND_CL_MACRO, 3'd0, 4'd1, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_RD_MACRO, 3'd1, 4'd8, '0, 8'h00, 1'b0, 1'b0);
		send_item(KIND_CL_WAKE, 3'd0, 4'd0, '0, 8'h00, 1'b0, 1'b0);
		go_idle();

		// Long receiver hold-off while the sender keeps offering codes.
		hold_off = 1'b1;
		for (int i = 0; i < 12; i++)
			send_item(KIND_CODE, 3'd0, 4'd0, code_pool[4], 8'h00, 1'b0, 1'b1);

		for (int i = 0; i < 140; i++) begin
			if (i == 115) calm = 1'b1;
			r = $urandom_range(0, 99);
			c = pool_code();
			if (r < 45) kind = KIND_CODE;
			else if (r < 65) kind = KIND_WR_MACRO;
			else if (r < 80) kind = KIND_WR_WAKE;
			else if (r < 85) kind = KIND_CL_MACRO;
			else if (r < 90) kind = KIND_CL_WAKE;
			else if (r < 94) kind = KIND_RD_MACRO;
			else if (r < 98) kind = KIND_RD_WAKE;
			else kind = KIND_UNUSED;
			if ($urandom_range(0, 9) == 0) c = 40'({$urandom, $urandom});
			// Flags of zero keep written entries matchable by received codes.
			send_item(kind,
				($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
				($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
				c, ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00,
				$urandom_range(0, 7) == 0, 1'($urandom));
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Run covered %0d input beats and %0d result beats over table items and codes.",
			items_sent, results_seen);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/irctm_pkg.sv
rtl/core/irctm_ram.sv
rtl/core/irctm_ctrl.sv
rtl/core/irctm_dp.sv
rtl/core/ir_code_trigger_matcher.sv
rtl/core/irctm_checker.sv
dv/ir_code_trigger_matcher_checker.sv
dv/ir_code_trigger_matcher_tb.sv
